/* rtl/core/hdlcrx_pkg.sv */
// Shared constants, codes and types for the HDLC-style frame receiver.
// No dependencies; used by every file in rtl/core.
package hdlcrx_pkg;

    // Sizing
    localparam int NUM_CHANNELS = 32;
    localparam int MAX_CAPACITY = 2048;
    localparam int LEN_W        = 12;
    localparam int MASK_W       = 32;
    localparam int CH_IDX_W     = 5;   // bits to pick one mask bit
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // Line bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLIP  = 8'h20;

    // Receive phases
    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_ADDR = 3'd1;
    localparam logic [2:0] PH_CTRL = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_ESC  = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;
    localparam logic [1:0] KIND_ABORT   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK  = 2'd1;

    localparam logic [LEN_W-1:0]  MAX_FRAME_LEN_RST = 12'd256;
    localparam logic [MASK_W-1:0] CHANNEL_MASK_RST  = '0;

    // One result beat from the decoder
    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [7:0]       data_byte;
        logic [7:0]       channel;
        logic [7:0]       control_byte;
        logic [LEN_W-1:0] frame_length;
    } result_t;

endpackage

/* rtl/core/hdlcrx_core.sv */
// Frame decoder: config registers, receive phase, frame header and payload count.
// Depends on hdlcrx_pkg. Produces at most one result per stepped byte.
module hdlcrx_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  logic [7:0]                          rx_byte,
    input  logic                                cfg_wr_en,
    input  logic [hdlcrx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hdlcrx_pkg::CFG_DATA_W-1:0]   cfg_data,
    output hdlcrx_pkg::result_t                 res
);

    logic [hdlcrx_pkg::LEN_W-1:0]  max_len_reg;
    logic [hdlcrx_pkg::MASK_W-1:0] mask_reg;
    logic [2:0]                    phase_reg, phase_next;
    logic [7:0]                    chan_reg, chan_next;
    logic [7:0]                    ctrl_reg, ctrl_next;
    logic [hdlcrx_pkg::LEN_W-1:0]  count_reg, count_next;

    logic [hdlcrx_pkg::LEN_W-1:0]  cap;
    logic [hdlcrx_pkg::LEN_W-1:0]  count_inc;
    logic                          chan_en;
    logic                          full;
    logic [7:0]                    store_val;
    logic                          do_store;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= hdlcrx_pkg::MAX_FRAME_LEN_RST;
            mask_reg    <= hdlcrx_pkg::CHANNEL_MASK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hdlcrx_pkg::REG_MAX_FRAME_LEN:
                    max_len_reg <= cfg_data[hdlcrx_pkg::LEN_W-1:0];
                hdlcrx_pkg::REG_CHANNEL_MASK:
                    mask_reg <= cfg_data[hdlcrx_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective capacity and channel enable
    assign cap = (max_len_reg > hdlcrx_pkg::LEN_W'(hdlcrx_pkg::MAX_CAPACITY))
               ? hdlcrx_pkg::LEN_W'(hdlcrx_pkg::MAX_CAPACITY) : max_len_reg;
    assign full      = (count_reg >= cap);
    assign count_inc = count_reg + 1'b1;
    assign chan_en   = (chan_reg < 8'(hdlcrx_pkg::NUM_CHANNELS))
                     && mask_reg[chan_reg[hdlcrx_pkg::CH_IDX_W-1:0]];

    // Next state and result
    always_comb begin
        phase_next = phase_reg;
        chan_next  = chan_reg;
        ctrl_next  = ctrl_reg;
        count_next = count_reg;
        do_store   = 1'b0;
        store_val  = rx_byte;

        res.valid        = 1'b0;
        res.kind         = hdlcrx_pkg::KIND_PAYLOAD;
        res.data_byte    = '0;
        res.channel      = chan_reg;
        res.control_byte = ctrl_reg;
        res.frame_length = count_reg;

        if (full) begin
            // overflow: discard byte, abort frame
            res.valid  = 1'b1;
            res.kind   = hdlcrx_pkg::KIND_ABORT;
            count_next = '0;
            phase_next = hdlcrx_pkg::PH_WAIT;
        end else begin
            case (phase_reg)
                hdlcrx_pkg::PH_ADDR: begin
                    chan_next  = rx_byte;
                    phase_next = hdlcrx_pkg::PH_CTRL;
                end
                hdlcrx_pkg::PH_CTRL: begin
                    ctrl_next  = rx_byte;
                    phase_next = hdlcrx_pkg::PH_DATA;
                end
                hdlcrx_pkg::PH_DATA: begin
                    if (rx_byte == hdlcrx_pkg::ESC_BYTE) begin
                        phase_next = hdlcrx_pkg::PH_ESC;
                    end else if (rx_byte == hdlcrx_pkg::FLAG_BYTE) begin
                        res.valid  = 1'b1;
                        res.kind   = chan_en ? hdlcrx_pkg::KIND_DELIVER
                                             : hdlcrx_pkg::KIND_DROP;
                        count_next = '0;
                        phase_next = hdlcrx_pkg::PH_WAIT;
                    end else begin
                        do_store = 1'b1;
                    end
                end
                hdlcrx_pkg::PH_ESC: begin
                    phase_next = hdlcrx_pkg::PH_DATA;
                    store_val  = rx_byte ^ hdlcrx_pkg::ESC_FLIP;
                    do_store   = 1'b1;
                end
                default: begin
                    phase_next = (rx_byte == hdlcrx_pkg::FLAG_BYTE)
                               ? hdlcrx_pkg::PH_ADDR : hdlcrx_pkg::PH_WAIT;
                end
            endcase

            // payload byte: count always, stream only for enabled channels
            if (do_store) begin
                count_next       = count_inc;
                res.valid        = chan_en;
                res.data_byte    = store_val;
                res.frame_length = count_inc;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hdlcrx_pkg::PH_WAIT;
            chan_reg  <= '0;
            ctrl_reg  <= '0;
            count_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
            ctrl_reg  <= ctrl_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/hdlc_style_frame_receiver.sv */
// Top level of the HDLC-style frame receiver: input register, decoder, result register.
// Depends on hdlcrx_pkg and hdlcrx_core.
//
//  channel | ports                                 | dir | notes
//  --------+---------------------------------------+-----+-----------------------------
//  s_      | s_valid s_ready s_rx_byte             | in  | one line byte per beat
//  m_      | m_valid m_ready m_kind .. m_frame_len | out | zero or one result per byte
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data| in  | 0 max_frame_len, 1 ch mask
//
// One byte per cycle sustained while m_ready stays high; an s_ beat goes through the input register,
// then the decoder into the result register, before its m_ beat.
// aresetn is synchronous, active low; clears control state and both registers' valid.
// A stalled m_ beat holds the byte in the input register; s_ready then follows m_ready.
// cfg_ready is always high.
module hdlc_style_frame_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_kind,
    output logic [7:0]                          m_data_byte,
    output logic [7:0]                          m_channel,
    output logic [7:0]                          m_control_byte,
    output logic [hdlcrx_pkg::LEN_W-1:0]        m_frame_length,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hdlcrx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hdlcrx_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                out_valid_reg, out_valid_next;
    hdlcrx_pkg::result_t out_reg;
    hdlcrx_pkg::result_t res;
    logic                out_free;
    logic                advance;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || advance;

    hdlcrx_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .rx_byte   (in_byte_reg),
        .cfg_wr_en (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res.valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (advance && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_data_byte    = out_reg.data_byte;
    assign m_channel      = out_reg.channel;
    assign m_control_byte = out_reg.control_byte;
    assign m_frame_length = out_reg.frame_length;

endmodule

/* rtl/core/hdlcrx_checker.sv */
// Port-level checks for hdlc_style_frame_receiver, bound to the top level.
// Depends on hdlcrx_pkg.
module hdlcrx_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [1:0]                          m_kind,
    input logic [7:0]                          m_data_byte,
    input logic [7:0]                          m_channel,
    input logic [7:0]                          m_control_byte,
    input logic [hdlcrx_pkg::LEN_W-1:0]        m_frame_length
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_data_byte)
            && $stable(m_channel) && $stable(m_control_byte) && $stable(m_frame_length))
        else $error("stalled result changed");

    // Only payload beats carry data
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != hdlcrx_pkg::KIND_PAYLOAD |-> m_data_byte == 8'd0)
        else $error("non-payload result carries data");

    // A streamed payload byte is always counted
    a_payload_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == hdlcrx_pkg::KIND_PAYLOAD |-> m_frame_length != '0)
        else $error("payload beat with zero length");

endmodule

bind hdlc_style_frame_receiver hdlcrx_checker u_hdlcrx_checker (.*);

/* tb/hdlc_frame_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the HDLC-style frame receiver: follows the config, line and result channels,
// predicts each result beat from its own deframer model and compares it field by field.
// Depends on hdlcrx_pkg only.
module hdlc_frame_checker
    import hdlcrx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [1:0]            m_kind,
    input  logic [7:0]            m_data_byte,
    input  logic [7:0]            m_channel,
    input  logic [7:0]            m_control_byte,
    input  logic [LEN_W-1:0]      m_frame_length,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  drain_done,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data_byte;
        logic [7:0]       channel;
        logic [7:0]       control_byte;
        logic [LEN_W-1:0] frame_length;
    } frame_event_t;

    // expected result beats, oldest first
    frame_event_t      expected_events[$];

    // shadow registers and deframer state
    logic [LEN_W-1:0]  cap_reg;
    logic [MASK_W-1:0] enable_mask;
    logic [2:0]        phase;
    logic [7:0]        cur_channel;
    logic [7:0]        cur_control;
    logic [LEN_W-1:0]  payload_len;
    int                result_no;
    bit                leftovers_done;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("result %0d: %s got 0x%0h, want 0x%0h",
                                      result_no, name, got_v, want_v));
    endtask

    // mask bits past the channel count never enable anything
    function automatic logic channel_on(input logic [7:0] ch);
        return (int'(ch) < NUM_CHANNELS) && (int'(ch) < MASK_W) &&
               enable_mask[ch[CH_IDX_W-1:0]];
    endfunction

    // advance the deframer by one line byte, queue the beat it causes if any
    task automatic decode_line_byte(input logic [7:0] b);
        frame_event_t     ev;
        logic [LEN_W-1:0] cap;
        logic             emit_ev;
        logic             store;
        logic [7:0]       stored;
        ev      = '0;
        emit_ev = 1'b0;
        store   = 1'b0;
        stored  = '0;
        cap = (int'(cap_reg) > MAX_CAPACITY) ? LEN_W'(MAX_CAPACITY) : cap_reg;
        // full frame aborts on any byte, in any phase
        if (payload_len >= cap) begin
            ev.kind         = KIND_ABORT;
            ev.frame_length = payload_len;
            emit_ev         = 1'b1;
            payload_len     = '0;
            phase           = PH_WAIT;
        end else begin
            case (phase)
                PH_ADDR: begin
                    cur_channel = b;
                    phase       = PH_CTRL;
                end
                PH_CTRL: begin
                    cur_control = b;
                    phase       = PH_DATA;
                end
                PH_DATA: begin
                    if (b == ESC_BYTE) begin
                        phase = PH_ESC;
                    end else if (b == FLAG_BYTE) begin
                        ev.kind         = channel_on(cur_channel) ? KIND_DELIVER : KIND_DROP;
                        ev.frame_length = payload_len;
                        emit_ev         = 1'b1;
                        payload_len     = '0;
                        phase           = PH_WAIT;
                    end else begin
                        store  = 1'b1;
                        stored = b;
                    end
                end
                PH_ESC: begin
                    phase  = PH_DATA;
                    store  = 1'b1;
                    stored = b ^ ESC_FLIP;
                end
                default: phase = (b == FLAG_BYTE) ? PH_ADDR : PH_WAIT;
            endcase
            // payload is counted always, streamed only for enabled channels
            if (store) begin
                payload_len = payload_len + 1'b1;
                if (channel_on(cur_channel)) begin
                    ev.kind         = KIND_PAYLOAD;
                    ev.data_byte    = stored;
                    ev.frame_length = payload_len;
                    emit_ev         = 1'b1;
                end
            end
        end
        if (emit_ev) begin
            ev.channel      = cur_channel;
            ev.control_byte = cur_control;
            expected_events.push_back(ev);
        end
    endtask

    always @(posedge aclk) begin
        frame_event_t got;
        frame_event_t want;
        if (!aresetn) begin
            cap_reg     = MAX_FRAME_LEN_RST;
            enable_mask = CHANNEL_MASK_RST;
            phase       = PH_WAIT;
            cur_channel = '0;
            cur_control = '0;
            payload_len = '0;
            expected_events.delete();
        end else begin
            if ($isunknown(m_valid))
                report_mismatch("m_valid is unknown");

            // result beat against the oldest expectation
            if (m_valid && m_ready) begin
                result_no++;
                got = '{m_kind, m_data_byte, m_channel, m_control_byte, m_frame_length};
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("result %0d: unexpected beat, kind %0d",
                                              result_no, m_kind));
                end else begin
                    want = expected_events.pop_front();
                    check_field("kind", got.kind, want.kind);
                    check_field("data_byte", got.data_byte, want.data_byte);
                    check_field("channel", got.channel, want.channel);
                    check_field("control_byte", got.control_byte, want.control_byte);
                    check_field("frame_length", got.frame_length, want.frame_length);
                end
            end

            // user rule: register writes land only while the block is idle; not enforced
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_FRAME_LEN: cap_reg = cfg_data[LEN_W-1:0];
                    REG_CHANNEL_MASK:  enable_mask = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                decode_line_byte(s_rx_byte);

            // anything still queued once stimulus has drained never arrived
            if (drain_done && !leftovers_done) begin
                leftovers_done = 1'b1;
                foreach (expected_events[i])
                    report_mismatch($sformatf("missing result, kind %0d length %0d",
                                              expected_events[i].kind,
                                              expected_events[i].frame_length));
            end
        end
        outstanding = expected_events.size();
    end

endmodule

/* tb/tb_hdlc_style_frame_receiver.sv */
`timescale 1ns / 1ps
// Top of the frame receiver testbench: clock, reset, line and config stimulus, result stalls.
// Depends on hdlcrx_pkg, hdlc_style_frame_receiver and hdlc_frame_checker.
module tb_hdlc_style_frame_receiver;
    import hdlcrx_pkg::*;

    localparam int CLK_HALF_NS     = 2;
    localparam int LIMIT_NS        = 4_000_000;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 170;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte      = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [1:0]            m_kind;
    logic [7:0]            m_data_byte;
    logic [7:0]            m_channel;
    logic [7:0]            m_control_byte;
    logic [LEN_W-1:0]      m_frame_length;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  drain_done     = 1'b0;
    int                    mismatches;
    int                    outstanding;
    int                    send_gap_pct   = 0;
    int                    recv_stall_pct = 0;
    int                    bytes_sent     = 0;

    always #(CLK_HALF_NS) aclk = ~aclk;

    hdlc_style_frame_receiver DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_channel      (m_channel),
        .m_control_byte (m_control_byte),
        .m_frame_length (m_frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    hdlc_frame_checker u_frame_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_channel      (m_channel),
        .m_control_byte (m_control_byte),
        .m_frame_length (m_frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .drain_done     (drain_done),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // result side stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic set_idling(input int gap_pct, input int stall_pct);
        send_gap_pct = gap_pct;
        recv_stall_pct <= stall_pct;
    endtask

    // one line beat; valid stays up until accepted, dropped only during a gap
    task automatic send_line_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_seq(input logic [7:0] seq[$]);
        foreach (seq[i]) send_line_byte(seq[i]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // both registers back to back, upper length bits random, maybe a stray index too
    task automatic configure(input logic [LEN_W-1:0] len, input logic [MASK_W-1:0] mask,
                             input bit with_spare);
        logic [CFG_DATA_W-1:0] upper;
        upper = $urandom;
        write_reg(REG_MAX_FRAME_LEN, {upper[CFG_DATA_W-1:LEN_W], len});
        write_reg(REG_CHANNEL_MASK, mask);
        if (with_spare)
            write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // idle the line, wait out every expected beat, then let the pipeline settle
    task automatic drain_pipeline();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        do begin
            @(negedge aclk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one frame with random content; when not clean, some bytes go out raw or broken
    task automatic send_frame(input int min_len, input int max_len, input bit clean);
        int         n_noise;
        int         n_payload;
        logic [7:0] b;
        bit         escape;
        n_noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n_noise) begin
            b = 8'($urandom);
            if (b == FLAG_BYTE) b = ~b;
            send_line_byte(b);
        end
        send_line_byte(FLAG_BYTE);
        if ($urandom_range(0, 9) == 0) b = 8'($urandom);
        else b = 8'($urandom_range(0, NUM_CHANNELS - 1));
        send_line_byte(b);
        send_line_byte(8'($urandom));
        n_payload = $urandom_range(min_len, max_len);
        repeat (n_payload) begin
            case ($urandom_range(0, 7))
                0:       b = FLAG_BYTE;
                1:       b = ESC_BYTE;
                default: b = 8'($urandom);
            endcase
            if (b == FLAG_BYTE || b == ESC_BYTE) escape = clean || ($urandom_range(0, 19) != 0);
            else escape = !clean && ($urandom_range(0, 15) == 0);
            if (escape) begin
                send_line_byte(ESC_BYTE);
                send_line_byte(b ^ ESC_FLIP);
            end else begin
                send_line_byte(b);
            end
        end
        // stray escape before the flag, or the closing flag left out
        if (!clean && $urandom_range(0, 14) == 0) send_line_byte(ESC_BYTE);
        if (clean || $urandom_range(0, 14) != 0) send_line_byte(FLAG_BYTE);
    endtask

    initial begin : stimulus
        logic [7:0]        line[$];
        logic [LEN_W-1:0]  len;
        logic [MASK_W-1:0] mask;
        int                budget;
        int                start;
        int                max_len;
        set_idling(11, 86);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: nothing enabled, so the frame is dropped
        line = {8'hFF, FLAG_BYTE, 8'h05, 8'h33, 8'h41, FLAG_BYTE};
        send_seq(line);
        drain_pipeline();

        // flag as control byte, escaped flag and escape, then a flag on a full frame;
        // then a flag as address, which is past the channel count
        configure(3, '1, 1'b1);
        line = {FLAG_BYTE, 8'h1F, FLAG_BYTE, ESC_BYTE, FLAG_BYTE, ESC_BYTE, 8'h5D, 8'hFF,
                FLAG_BYTE, FLAG_BYTE, FLAG_BYTE, 8'h00, 8'h01, FLAG_BYTE};
        send_seq(line);
        drain_pipeline();

        // zero capacity aborts on every byte
        configure(0, 32'h0000_0001, 1'b0);
        line = {FLAG_BYTE, 8'h00};
        send_seq(line);
        drain_pipeline();

        // capacity of one, empty frame on channel zero is delivered
        configure(1, 32'h8000_0001, 1'b1);
        line = {FLAG_BYTE, 8'h00, 8'h55, FLAG_BYTE};
        send_seq(line);
        drain_pipeline();

        // random frames under a series of settings and idling modes
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 4) set_idling(11, 86);
            else if (p < 8) set_idling(86, 11);
            else set_idling(0, 0);
            budget = ITEMS_PER_PHASE;
            len    = LEN_W'($urandom_range(1, 40));
            mask   = $urandom;
            case (p)
                0: begin
                    len  = 1;
                    mask = '1;
                end
                2: begin
                    len    = 0;
                    budget = 40;
                end
                5: mask = '0;
                7: begin
                    len  = LEN_W'($urandom_range(41, 300));
                    mask = '1;
                end
                NUM_PHASES - 1: begin
                    len  = '1;
                    mask = '1;
                end
                default: ;
            endcase
            configure(len, mask, 1'($urandom_range(0, 1)));
            max_len = (int'(len) > 300) ? 40 : int'(len) + 3;
            start   = bytes_sent;
            while (bytes_sent - start < budget) send_frame(0, max_len, 1'b0);
            drain_pipeline();
        end

        drain_done <= 1'b1;
        @(negedge aclk);
        @(negedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
